>>> hdl/printable_run_extractor_assert.svh
// assertion macros shared by the printable run extractor rtl
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef PRINTABLE_RUN_EXTRACTOR_ASSERT_SVH
`define PRINTABLE_RUN_EXTRACTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// clocked check, disabled while reset is asserted
`define PRE_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked check that also holds through reset
`define PRE_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRE_ASSERT(lbl, clk, rstn, prop, msg)
`define PRE_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/pre_pkg.sv
// types, constants and byte classification for the printable run extractor
// no dependencies
`default_nettype none
package pre_pkg;
	localparam int BUFFER_BYTES = 64;
	localparam int OFFSET_BITS  = 32;
	localparam int FLUSH_SIZE   = BUFFER_BYTES - 2;
	localparam int LEN_W        = $clog2(BUFFER_BYTES) + 1;
	localparam int RING_AW      = $clog2(BUFFER_BYTES) + 1;
	localparam int RING_DEPTH   = 1 << RING_AW;
	localparam int PTR_W        = RING_AW + 1;
	localparam int DESC_DEPTH   = 4;
	localparam int DESC_AW      = 2;
	localparam int OUT_DEPTH    = 4;
	localparam int OUT_AW       = 2;
	localparam int MIN_LEN_W    = 6;
	localparam int CMP_W        = LEN_W + MIN_LEN_W;
	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_DATA_W   = 32;
	localparam int BASE_W       = 32;

	localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 6'd4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MIN_LENGTH  = 1'b0,
		REG_BASE_OFFSET = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CLS_TERM  = 2'd0,
		CLS_TEXT  = 2'd1,
		CLS_OTHER = 2'd2
	} byte_class_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       section_start;
	} item_t;

	typedef struct packed {
		logic [7:0]  text_byte;
		logic [31:0] run_offset;
		logic        run_end;
	} result_t;

	typedef struct packed {
		logic [RING_AW-1:0]     start;
		logic [LEN_W-1:0]       len;
		logic [OFFSET_BITS-1:0] offset;
	} desc_t;

	typedef struct packed {
		logic             desc_full;
		logic [PTR_W-1:0] tail;
	} back_status_t;

	function automatic byte_class_t classify(input logic [7:0] c);
		byte_class_t cls;
		if (c == CH_NL || c == CH_NUL) begin
			cls = CLS_TERM;
		end else if (c == CH_TAB || c == CH_BS || (c >= CH_SPACE && c <= CH_TILDE)) begin
			cls = CLS_TEXT;
		end else begin
			cls = CLS_OTHER;
		end
		return cls;
	endfunction
endpackage
`default_nettype wire

>>> hdl/pre_ram.sv
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none
module pre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> hdl/pre_front.sv
// front end: takes bytes, classifies them, tracks the run and stream position
// depends on pre_pkg; writes run bytes to the ring ram and queues run descriptors
`default_nettype none
module pre_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire pre_pkg::item_t                    item,
	input  wire logic                              cfg_valid,
	input  wire logic [pre_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [pre_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire pre_pkg::back_status_t             back_status,
	output logic                                   desc_push,
	output pre_pkg::desc_t                         desc,
	output logic                                   ram_we,
	output logic [pre_pkg::RING_AW-1:0]            ram_waddr,
	output logic [7:0]                             ram_wdata
);
	import pre_pkg::*;

	logic [MIN_LEN_W-1:0]   min_length_q;
	logic [BASE_W-1:0]      base_offset_q;
	logic [LEN_W-1:0]       run_length_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [PTR_W-1:0]       run_base_q;

	logic                   accept;
	byte_class_t            cls;
	logic [LEN_W-1:0]       len_eff;
	logic [LEN_W-1:0]       len_inc;
	logic [OFFSET_BITS-1:0] pos_cur;
	logic [MIN_LEN_W-1:0]   need;
	logic                   term_emit;
	logic                   flush_hit;
	logic                   flush_emit;
	logic [PTR_W-1:0]       wr_ptr;
	logic [PTR_W-1:0]       used;
	logic                   ring_full;

	// ring space: committed runs not yet read plus the run being built
	assign used      = run_base_q - back_status.tail;
	assign ring_full = ({1'b0, used} + (PTR_W+1)'(run_length_q)) >= (PTR_W+1)'(RING_DEPTH);
	assign full      = back_status.desc_full | ring_full;
	assign accept    = push & ~full;

	assign cls     = classify(item.data_byte);
	assign len_eff = item.section_start ? '0 : run_length_q;
	assign len_inc = len_eff + LEN_W'(1);
	assign pos_cur = item.section_start ? OFFSET_BITS'(base_offset_q) : pos_q;
	assign need    = (min_length_q == '0) ? MIN_LEN_W'(1) : min_length_q;

	assign term_emit  = (cls == CLS_TERM) && (CMP_W'(len_eff) >= CMP_W'(need));
	assign flush_hit  = (cls == CLS_TEXT) && (len_inc == LEN_W'(FLUSH_SIZE));
	assign flush_emit = flush_hit && (CMP_W'(FLUSH_SIZE) >= CMP_W'(need));

	assign desc_push   = accept && (term_emit || flush_emit);
	assign desc.start  = run_base_q[RING_AW-1:0];
	assign desc.len    = term_emit ? len_eff : len_inc;
	// same start offset for terminator and flush: the flushing byte is in the run
	assign desc.offset = pos_cur - OFFSET_BITS'(len_eff);

	assign wr_ptr    = run_base_q + PTR_W'(len_eff);
	assign ram_we    = accept && (cls == CLS_TEXT);
	assign ram_waddr = wr_ptr[RING_AW-1:0];
	assign ram_wdata = item.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q  <= MIN_LEN_RESET;
			base_offset_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_MIN_LENGTH:  min_length_q  <= cfg_data[MIN_LEN_W-1:0];
				REG_BASE_OFFSET: base_offset_q <= cfg_data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q <= '0;
			pos_q        <= '0;
			run_base_q   <= '0;
		end else if (accept) begin
			pos_q <= pos_cur + OFFSET_BITS'(1);
			case (cls)
				CLS_TERM: begin
					run_length_q <= '0;
					if (term_emit) begin
						run_base_q <= run_base_q + PTR_W'(len_eff);
					end
				end
				CLS_TEXT: begin
					if (flush_hit) begin
						run_length_q <= '0;
						if (flush_emit) begin
							run_base_q <= run_base_q + PTR_W'(len_inc);
						end
					end else begin
						run_length_q <= len_inc;
					end
				end
				default: run_length_q <= '0;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hdl/pre_back.sv
// back end: descriptor queue, byte read-out from the ring ram and result queue
// depends on pre_pkg and the assertion macro header
`default_nettype none
`include "printable_run_extractor_assert.svh"
module pre_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          desc_push,
	input  wire pre_pkg::desc_t                desc,
	output pre_pkg::back_status_t              status,
	output logic [pre_pkg::RING_AW-1:0]        ram_raddr,
	input  wire logic [7:0]                    ram_rdata,
	input  wire logic                          pop,
	output logic                               empty,
	output pre_pkg::result_t                   result
);
	import pre_pkg::*;

	desc_t                  dmem_q [DESC_DEPTH];
	logic [DESC_AW-1:0]     dwr_q;
	logic [DESC_AW-1:0]     drd_q;
	logic [DESC_AW:0]       dcnt_q;
	logic [LEN_W-1:0]       idx_q;
	logic [PTR_W-1:0]       tail_q;

	logic                   v_s1;
	logic [OFFSET_BITS-1:0] offset_s1;
	logic                   end_s1;

	result_t                omem_q [OUT_DEPTH];
	logic [OUT_AW-1:0]      owr_q;
	logic [OUT_AW-1:0]      ord_q;
	logic [OUT_AW:0]        ocnt_q;

	desc_t                  head;
	logic                   out_room;
	logic                   issue;
	logic                   last;
	logic                   dpop;
	logic                   opop;

	assign head     = dmem_q[drd_q];
	assign out_room = ((OUT_AW+2)'(ocnt_q) + (OUT_AW+2)'(v_s1)) < (OUT_AW+2)'(OUT_DEPTH);
	assign issue    = (dcnt_q != '0) && out_room;
	assign last     = (idx_q + LEN_W'(1)) == head.len;
	assign dpop     = issue && last;
	assign ram_raddr = head.start + RING_AW'(idx_q);

	assign status.desc_full = dcnt_q == (DESC_AW+1)'(DESC_DEPTH);
	assign status.tail      = tail_q;

	assign empty  = ocnt_q == '0;
	assign opop   = pop && !empty;
	assign result = omem_q[ord_q];

	// descriptor queue
	always_ff @(posedge clk) begin
		if (desc_push) begin
			dmem_q[dwr_q] <= desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwr_q  <= '0;
			drd_q  <= '0;
			dcnt_q <= '0;
			idx_q  <= '0;
			tail_q <= '0;
		end else begin
			if (desc_push) begin
				dwr_q <= dwr_q + DESC_AW'(1);
			end
			if (dpop) begin
				drd_q <= drd_q + DESC_AW'(1);
			end
			dcnt_q <= dcnt_q + (DESC_AW+1)'(desc_push) - (DESC_AW+1)'(dpop);
			if (issue) begin
				idx_q  <= last ? '0 : idx_q + LEN_W'(1);
				tail_q <= tail_q + PTR_W'(1);
			end
		end
	end

	// read stage, ram data lands alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			offset_s1 <= head.offset;
			end_s1    <= last;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (v_s1) begin
			omem_q[owr_q] <= '{text_byte: ram_rdata, run_offset: 32'(offset_s1), run_end: end_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (v_s1) begin
				owr_q <= owr_q + OUT_AW'(1);
			end
			if (opop) begin
				ord_q <= ord_q + OUT_AW'(1);
			end
			ocnt_q <= ocnt_q + (OUT_AW+1)'(v_s1) - (OUT_AW+1)'(opop);
		end
	end

	`PRE_ASSERT(a_desc_no_overflow, clk, arst_n, desc_push |-> !status.desc_full, "descriptor queue overflow")
	`PRE_ASSERT(a_issue_to_s1, clk, arst_n, issue |=> v_s1, "read issue lost before read stage")
	`PRE_ASSERT(a_last_marks_end, clk, arst_n, (issue && last) |=> end_s1, "last byte of run not marked")
	`PRE_ASSERT(a_out_bound, clk, arst_n, ocnt_q <= (OUT_AW+1)'(OUT_DEPTH), "result queue overflow")
endmodule
`default_nettype wire

>>> hdl/printable_run_extractor.sv
// top level of the printable run extractor: front end, ring ram and back end
// depends on pre_pkg, pre_front, pre_back and pre_ram
//
// usage
//  - input queue: drive item (data_byte, section_start) and raise push; the byte
//    is taken at a rising edge with push high and full low
//  - result queue: while empty is low, result holds the oldest character of an
//    emitted run (text_byte, run_offset, run_end); raise pop to take it
//  - config: cfg_valid with cfg_index/cfg_data; cfg_ready is always high, so
//    every valid cycle is a transfer (index 0 min_length, index 1 base_offset)
//  - the front end takes one byte per cycle while full is low; a qualifying run
//    is queued as a descriptor at the transfer of its terminating or filling byte
//  - the first character of a run reaches result through the ring ram read and
//    the read stage, then characters follow one per cycle while pop is held
//  - the back end reads the byte ring ram once per character, so its drain rate
//    is one character per cycle while the result queue has room; full rises when
//    the descriptor queue or the ring ram (twice the run buffer) has no room
//  - a stalled receiver fills the four-entry result queue, then the read-out
//    pauses, then descriptors and ring data back up until full rises
//  - reset clears run state, position, queues and config; the ring ram is not cleared
`default_nettype none
module printable_run_extractor (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire pre_pkg::item_t                    item,
	output logic                                   empty,
	input  wire logic                              pop,
	output pre_pkg::result_t                       result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [pre_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [pre_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pre_pkg::*;

	back_status_t       back_status;
	desc_t              desc;
	logic               desc_push;
	logic               ram_we;
	logic [RING_AW-1:0] ram_waddr;
	logic [7:0]         ram_wdata;
	logic [RING_AW-1:0] ram_raddr;
	logic [7:0]         ram_rdata;

	// registers are always writable
	assign cfg_ready = 1'b1;

	// classification, run tracking, descriptor generation
	pre_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.back_status (back_status),
		.desc_push   (desc_push),
		.desc        (desc),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata)
	);

	// ring of run bytes shared by both ends
	pre_ram #(
		.WIDTH (8),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// descriptor drain and result queue
	pre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc_push (desc_push),
		.desc      (desc),
		.status    (back_status),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);
endmodule
`default_nettype wire

>>> dv/printable_run_extractor_test.sv
// self-checking testbench for printable_run_extractor: a directed burst, then random byte streams
// built from text runs, with random idling on both queue sides and several register settings
// depends on pre_pkg and the printable_run_extractor rtl
`default_nettype none
module printable_run_extractor_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pre_pkg::*;

	// cycles with no transfer of any kind before the run is abandoned
	localparam int IDLE_LIMIT    = 4000;
	// settle time after the last owed character; allow generous slack
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASES        = 8;

	// tracks the run state of the block and holds the characters still owed by it
	class run_tracker;
		logic [7:0]  run_buf [BUFFER_BYTES];
		int unsigned run_len;
		logic [31:0] stream_pos;
		logic [5:0]  min_len;
		logic [31:0] base_off;
		result_t     chars_due [$];
		int          mismatches;

		function new();
			run_len    = 0;
			stream_pos = '0;
			min_len    = MIN_LEN_RESET;
			base_off   = '0;
			mismatches = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [31:0] val);
			case (idx)
				REG_MIN_LENGTH: begin
					min_len = val[5:0];
				end
				REG_BASE_OFFSET: begin
					base_off = val;
				end
				default: begin
				end
			endcase
		endfunction

		// a finished run is owed only when long enough; zero counts as one
		function void queue_run(logic [31:0] start);
			int unsigned need;
			int unsigned i;
			result_t     ch;
			need = (min_len == 0) ? 1 : int'(min_len);
			if (run_len >= need) begin
				for (i = 0; i < run_len; i++) begin
					ch.text_byte  = run_buf[i];
					ch.run_offset = start;
					ch.run_end    = (i + 1 == run_len);
					chars_due.push_back(ch);
				end
			end
			run_len = 0;
		endfunction

		function void take_byte(item_t it);
			logic [7:0]  c;
			logic [31:0] pos;
			c = it.data_byte;
			if (it.section_start) begin
				run_len    = 0;
				stream_pos = base_off;
			end
			pos = stream_pos;
			if (c == CH_NL || c == CH_NUL) begin
				queue_run(pos - run_len);
			end else if (c == CH_TAB || c == CH_BS || (c >= CH_SPACE && c <= CH_TILDE)) begin
				run_buf[run_len] = c;
				run_len++;
				// the filling byte belongs to the run, hence the plus one
				if (run_len >= FLUSH_SIZE) begin
					queue_run(pos - run_len + 1);
				end
			end else begin
				run_len = 0;
			end
			stream_pos = pos + 1;
		endfunction

		task flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
			if (mismatches < 40) begin
				$display("%s mismatch: got %0h, expected %0h", field, got, want);
			end
			mismatches++;
		endtask

		task check_char(result_t got);
			result_t want;
			if (chars_due.size() == 0) begin
				flag_mismatch("unexpected character", 32'(got.text_byte), '0);
				return;
			end
			want = chars_due.pop_front();
			if (got.text_byte !== want.text_byte) begin
				flag_mismatch("text_byte", 32'(got.text_byte), 32'(want.text_byte));
			end
			if (got.run_offset !== want.run_offset) begin
				flag_mismatch("run_offset", got.run_offset, want.run_offset);
			end
			if (got.run_end !== want.run_end) begin
				flag_mismatch("run_end", 32'(got.run_end), 32'(want.run_end));
			end
		endtask
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   push      = 1'b0;
	logic                   full;
	item_t                  item      = '0;
	logic                   empty;
	logic                   pop       = 1'b0;
	result_t                result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	run_tracker tracker;
	// no idling on either side while set
	bit         calm = 1'b0;
	int         pop_hold = 0;
	int         idle_cycles = 0;

	printable_run_extractor uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// text byte, tab and backspace now and then
	function automatic logic [7:0] text_char();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return CH_TAB;
		end else if (r == 1) begin
			return CH_BS;
		end
		return 8'($urandom_range(CH_SPACE, CH_TILDE));
	endfunction

	// a byte that is neither text nor a terminator
	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == CH_NL || c == CH_NUL || c == CH_TAB || c == CH_BS ||
			(c >= CH_SPACE && c <= CH_TILDE));
		return c;
	endfunction

	// result side: check each transfer, then choose pop for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				tracker.check_char(result);
			end
			if (calm) begin
				pop <= 1'b1;
			end else if (pop_hold > 0) begin
				pop <= 1'b0;
				pop_hold--;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 3) == 0) begin
					pop_hold = pick_gap();
				end
			end
		end
	end

	// watchdog: any transfer restarts the count
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("printable_run_extractor_test: FAIL");
			$finish;
		end
	end

	// one byte through the input queue; push stays high for a back-to-back transfer
	task send_item(logic [7:0] b, bit ss);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push                <= 1'b1;
		item.data_byte      <= b;
		item.section_start  <= ss;
		@(posedge clk);
		while (full) @(posedge clk);
		tracker.take_byte('{data_byte: b, section_start: ss});
	endtask

	// both registers, back to back; random upper bits on the min_length write
	task configure(int min_val, logic [31:0] base_val);
		cfg_reg_t    idx;
		logic [31:0] data;
		for (int k = 0; k < 2; k++) begin
			idx = (k == 0) ? REG_MIN_LENGTH : REG_BASE_OFFSET;
			if (k == 0) begin
				data      = $urandom();
				data[5:0] = 6'(min_val);
			end else begin
				data = base_val;
			end
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= data;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			tracker.set_reg(idx, data);
		end
		cfg_valid <= 1'b0;
	endtask

	// stop pushing, let every owed character out, then give a byte still in flight time to land
	task quiesce();
		push <= 1'b0;
		while (tracker.chars_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random stream: mostly text runs with a terminator, some junk and hanging runs
	task run_phase(int n_items, int long_pct);
		int  sent;
		int  len;
		int  r;
		bit  next_ss;
		sent    = 0;
		next_ss = 1'b1;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				send_item(8'($urandom_range(0, 255)), next_ss || $urandom_range(0, 19) == 0);
				next_ss = 1'b0;
				sent++;
			end else begin
				len = ($urandom_range(0, 99) < long_pct) ? $urandom_range(58, 70)
					: $urandom_range(0, 10);
				for (int k = 0; k < len; k++) begin
					send_item(text_char(), (k == 0) && (next_ss || $urandom_range(0, 9) == 0));
					next_ss = 1'b0;
					sent++;
				end
				r = $urandom_range(0, 99);
				if (r < 75) begin
					send_item($urandom_range(0, 1) ? CH_NL : CH_NUL, next_ss);
					next_ss = 1'b0;
					sent++;
				end else if (r < 90) begin
					send_item(junk_char(), next_ss);
					next_ss = 1'b0;
					sent++;
				end else begin
					// hanging run, often cut off by a new section
					next_ss = $urandom_range(0, 1);
				end
			end
		end
	endtask

	// directed burst as {section_start, data_byte}
	localparam logic [8:0] DIRECTED [25] = '{
		// lowest and highest text bytes, tab, backspace, then newline: emitted at offset 0
		9'h020, 9'h07E, 9'h009, 9'h008, 9'h00A,
		// too short, ended by nul
		9'h078, 9'h079, 9'h000,
		// long enough but cut by delete
		9'h041, 9'h042, 9'h043, 9'h044, 9'h07F,
		// junk bytes on their own
		9'h0FF, 9'h080, 9'h01F,
		// run left open, dropped by a section start, new run from base_offset
		9'h071, 9'h072, 9'h073, 9'h074,
		9'h16B, 9'h06C, 9'h06D, 9'h06E, 9'h00A
	};

	int          min_set  [PHASES];
	logic [31:0] base_set [PHASES];
	int          size_set [PHASES];
	int          long_set [PHASES];

	initial begin
		tracker = new();
		// min_length, base_offset, least items (a phase overshoots by its last run),
		// share of long runs in percent
		min_set  = '{1, 0, 62, 63, 4, $urandom_range(1, 62), 2, $urandom_range(1, 8)};
		base_set = '{32'h0, $urandom(), 32'hFFFF_FFE0, $urandom(), 32'hFFFF_FFFF, $urandom(),
			32'h0, 32'h8000_0000};
		size_set = '{15, 15, 30, 20, 15, 15, 15, 15};
		long_set = '{10, 10, 60, 40, 15, 15, 15, 15};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part runs on the reset values of the registers
		foreach (DIRECTED[i]) begin
			send_item(DIRECTED[i][7:0], DIRECTED[i][8]);
		end
		quiesce();

		for (int p = 0; p < PHASES; p++) begin
			configure(min_set[p], base_set[p]);
			calm = (p % 3 == 0);
			run_phase(size_set[p], long_set[p]);
			quiesce();
		end

		if (tracker.mismatches == 0) begin
			$display("printable_run_extractor_test: PASS");
		end else begin
			$display("printable_run_extractor_test: FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
